// ----- hw/rtl/dqmm_pkg.sv -----
`default_nettype none

package dqmm_pkg;

    // Default sizing of the ring buffer.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the channel beats.
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Request beat.
    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] push_value;
    } req_beat_t;

    // Response beat.
    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] largest_value;
        logic signed [VALUE_W-1:0] smallest_value;
        logic [STATUS_W-1:0]       status;
    } rsp_beat_t;

    // Control from the sequencer to the scan compare unit.
    typedef struct packed {
        logic start;
        logic sample;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dqmm_minmax.sv -----
`default_nettype none

module dqmm_minmax #(
    parameter int DATA_WIDTH = dqmm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dqmm_pkg::scan_ctl_t          ctl,
    input  wire logic signed [DATA_WIDTH-1:0] sample_data,
    output logic signed [DATA_WIDTH-1:0]      front_value,
    output logic signed [DATA_WIDTH-1:0]      back_value,
    output logic signed [DATA_WIDTH-1:0]      largest_value,
    output logic signed [DATA_WIDTH-1:0]      smallest_value
);

    logic                         first_reg;
    logic signed [DATA_WIDTH-1:0] front_reg;
    logic signed [DATA_WIDTH-1:0] back_reg;
    logic signed [DATA_WIDTH-1:0] hi_reg;
    logic signed [DATA_WIDTH-1:0] lo_reg;

    // The first sample of a scan seeds every register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.start)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.sample)
        begin
            first_reg <= 1'b0;
        end
    end

    // Shared compare unit: one entry per cycle against the running extremes.
    always_ff @(posedge clk)
    begin
        if (ctl.sample)
        begin
            back_reg <= sample_data;
            if (first_reg)
            begin
                front_reg <= sample_data;
                hi_reg    <= sample_data;
                lo_reg    <= sample_data;
            end
            else
            begin
                if (sample_data > hi_reg)
                begin
                    hi_reg <= sample_data;
                end
                if (sample_data < lo_reg)
                begin
                    lo_reg <= sample_data;
                end
            end
        end
    end

    assign front_value    = front_reg;
    assign back_value     = back_reg;
    assign largest_value  = hi_reg;
    assign smallest_value = lo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/deque_with_min_max.sv -----
`default_nettype none

// Channel  Beat        Valid      Stall      Role
// req      req_data    req_valid  req_stall  opcode and push value in
// rsp      rsp_data    rsp_valid  rsp_stall  front, back, count, extremes, status out
//
// An item goes from idle through the update, scan, drain and done states before the next
// one can be accepted; the scan and drain are skipped when the deque ends empty. The scan
// reads the entries left after the operation through the one read port, one entry a cycle.
// Reset clears the pointers, the count and the handshakes; ring memory is not cleared.
// A stalled response waits in its output register while the next request is taken.

module deque_with_min_max #(
    parameter int CAPACITY   = dqmm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = dqmm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire dqmm_pkg::req_beat_t req_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output dqmm_pkg::rsp_beat_t      rsp_data
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] WRAP_SUM   = SUM_W'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [dqmm_pkg::OPCODE_W-1:0]      op_reg;
    logic [DATA_WIDTH-1:0]              value_reg;
    logic [PTR_W-1:0]                   front_reg;
    logic [PTR_W-1:0]                   front_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [dqmm_pkg::STATUS_W-1:0]      status_reg;
    logic [dqmm_pkg::STATUS_W-1:0]      status_next;
    logic [PTR_W-1:0]                   scan_ptr_reg;
    logic [PTR_W-1:0]                   scan_ptr_next;
    logic [CNT_W-1:0]                   scan_left_reg;
    logic [CNT_W-1:0]                   scan_left_next;
    logic                               rd_vld_reg;
    logic signed [DATA_WIDTH-1:0]       rd_data_reg;
    logic [DATA_WIDTH-1:0]              ring_mem [CAPACITY];
    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    dqmm_pkg::rsp_beat_t                rsp_reg;
    dqmm_pkg::rsp_beat_t                rsp_next;

    logic signed [63:0]                 push_wide;
    logic                               is_push;
    logic                               is_pop;
    logic [PTR_W-1:0]                   front_dec;
    logic [PTR_W-1:0]                   front_inc;
    logic [PTR_W-1:0]                   scan_inc;
    logic [SUM_W-1:0]                   back_sum;
    logic [SUM_W-1:0]                   back_wrap;
    logic [PTR_W-1:0]                   back_slot;
    logic                               mem_we;
    logic [PTR_W-1:0]                   mem_waddr;
    logic [PTR_W-1:0]                   new_front;
    logic [CNT_W-1:0]                   new_count;
    dqmm_pkg::scan_ctl_t                scan_ctl;
    logic                               rsp_load;

    logic signed [DATA_WIDTH-1:0]       mm_front;
    logic signed [DATA_WIDTH-1:0]       mm_back;
    logic signed [DATA_WIDTH-1:0]       mm_hi;
    logic signed [DATA_WIDTH-1:0]       mm_lo;
    logic signed [63:0]                 front_wide;
    logic signed [63:0]                 back_wide;
    logic signed [63:0]                 hi_wide;
    logic signed [63:0]                 lo_wide;
    logic [15:0]                        count_wide;

    // Request value sign-extended, then kept at the storage width.
    assign push_wide = 64'(req_data.push_value);

    // Opcode decode; unused codes fall through as a query.
    assign is_push = (op_reg == dqmm_pkg::OP_PUSH_FRONT) || (op_reg == dqmm_pkg::OP_PUSH_BACK);
    assign is_pop  = (op_reg == dqmm_pkg::OP_POP_FRONT) || (op_reg == dqmm_pkg::OP_POP_BACK);

    // Ring pointer arithmetic with wrap at the capacity.
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
    assign scan_inc  = (scan_ptr_reg == LAST_SLOT) ? '0 : scan_ptr_reg + 1'b1;
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_wrap = (back_sum >= WRAP_SUM) ? back_sum - WRAP_SUM : back_sum;
    assign back_slot = back_wrap[PTR_W-1:0];

    // Sequencer: update the ring, then scan the stored entries one a cycle.
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        mem_we         = 1'b0;
        mem_waddr      = back_slot;
        new_front      = front_reg;
        new_count      = count_reg;
        scan_ctl.start  = 1'b0;
        scan_ctl.sample = rd_vld_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                scan_ctl.start = 1'b1;
                status_next    = dqmm_pkg::ST_OK;
                if (is_push)
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        status_next = dqmm_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        new_count = count_reg + 1'b1;
                        if (op_reg == dqmm_pkg::OP_PUSH_FRONT)
                        begin
                            new_front = front_dec;
                            mem_waddr = front_dec;
                        end
                    end
                end
                else if (is_pop)
                begin
                    if (count_reg == '0)
                    begin
                        status_next = dqmm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        new_count = count_reg - 1'b1;
                        if (op_reg == dqmm_pkg::OP_POP_FRONT)
                        begin
                            new_front = front_inc;
                        end
                    end
                end
                front_next     = new_front;
                count_next     = new_count;
                scan_ptr_next  = new_front;
                scan_left_next = new_count;
                state_next     = (new_count == '0) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                scan_ptr_next  = scan_inc;
                scan_left_next = scan_left_reg - 1'b1;
                if (scan_left_reg == CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            status_reg    <= dqmm_pkg::ST_OK;
            scan_ptr_reg  <= '0;
            scan_left_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_left_reg <= scan_left_next;
            rd_vld_reg    <= (state_reg == S_SCAN);
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request capture on an accepted beat.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            op_reg    <= req_data.opcode;
            value_reg <= push_wide[DATA_WIDTH-1:0];
        end
    end

    // Ring memory: one write port, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= value_reg;
        end
        rd_data_reg <= ring_mem[scan_ptr_reg];
    end

    dqmm_minmax #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_minmax (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (scan_ctl),
        .sample_data    (rd_data_reg),
        .front_value    (mm_front),
        .back_value     (mm_back),
        .largest_value  (mm_hi),
        .smallest_value (mm_lo)
    );

    // Response assembly: values widened to the field width, zeros when empty.
    assign front_wide = 64'(mm_front);
    assign back_wide  = 64'(mm_back);
    assign hi_wide    = 64'(mm_hi);
    assign lo_wide    = 64'(mm_lo);
    assign count_wide = 16'(count_reg);

    always_comb
    begin
        rsp_next.entry_count = count_wide[dqmm_pkg::COUNT_W-1:0];
        rsp_next.status      = status_reg;
        if (count_reg == '0)
        begin
            rsp_next.front_value    = '0;
            rsp_next.back_value     = '0;
            rsp_next.largest_value  = '0;
            rsp_next.smallest_value = '0;
        end
        else
        begin
            rsp_next.front_value    = front_wide[dqmm_pkg::VALUE_W-1:0];
            rsp_next.back_value     = back_wide[dqmm_pkg::VALUE_W-1:0];
            rsp_next.largest_value  = hi_wide[dqmm_pkg::VALUE_W-1:0];
            rsp_next.smallest_value = lo_wide[dqmm_pkg::VALUE_W-1:0];
        end
    end

    // Output register: loaded when the scan is done and the slot is free.
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The entry count never goes past the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    // An accepted request always starts the ring update next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_UPDATE))
        else $error("accepted request did not start an update");

    // The scan never runs with no entries left to read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_left_reg != '0))
        else $error("scan running with nothing left");

    // A new response beat only comes out of the completion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside completion");

endmodule

`default_nettype wire

// ----- verif/deque_with_min_max_tb.sv -----
`timescale 1ns / 1ps

module deque_with_min_max_tb;

    localparam int CAP   = dqmm_pkg::CAPACITY_DEF;
    localparam int IDX_W = $clog2(CAP);

    // Opcodes outside the defined set behave as a query.
    localparam logic [dqmm_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [dqmm_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam int MAX_REPORTED = 10;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 2 * CAP + 20;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    dqmm_pkg::req_beat_t req_data  = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    dqmm_pkg::rsp_beat_t rsp_data;

    // Shadow copy of the deque contents.
    logic signed [dqmm_pkg::VALUE_W-1:0] ring_image [CAP];
    logic [IDX_W-1:0]                    head_idx;
    logic [dqmm_pkg::COUNT_W-1:0]        fill_count;

    dqmm_pkg::req_beat_t pending_reqs[$];
    dqmm_pkg::rsp_beat_t expected_reports[$];

    int total_items;
    int accepted_count;
    int report_count;
    int mismatches;
    int send_gap;
    int send_calm;
    int hold_left;
    int hold_calm;

    dqmm_pkg::rsp_beat_t want;

    deque_with_min_max dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the shadow deque and return the report it should produce.
    function automatic dqmm_pkg::rsp_beat_t apply_deque_op(dqmm_pkg::req_beat_t beat);
        dqmm_pkg::rsp_beat_t                 r;
        logic [IDX_W-1:0]                    idx;
        logic signed [dqmm_pkg::VALUE_W-1:0] hi;
        logic signed [dqmm_pkg::VALUE_W-1:0] lo;
        r = '0;
        r.status = dqmm_pkg::ST_OK;
        case (beat.opcode)
            dqmm_pkg::OP_PUSH_FRONT, dqmm_pkg::OP_PUSH_BACK:
            begin
                if (fill_count == dqmm_pkg::COUNT_W'(CAP))
                begin
                    r.status = dqmm_pkg::ST_FULL;
                end
                else if (beat.opcode == dqmm_pkg::OP_PUSH_FRONT)
                begin
                    head_idx = head_idx - 1'b1;
                    ring_image[head_idx] = beat.push_value;
                    fill_count = fill_count + 1'b1;
                end
                else
                begin
                    idx = head_idx + IDX_W'(fill_count);
                    ring_image[idx] = beat.push_value;
                    fill_count = fill_count + 1'b1;
                end
            end
            dqmm_pkg::OP_POP_FRONT, dqmm_pkg::OP_POP_BACK:
            begin
                if (fill_count == '0)
                begin
                    r.status = dqmm_pkg::ST_EMPTY;
                end
                else
                begin
                    if (beat.opcode == dqmm_pkg::OP_POP_FRONT)
                        head_idx = head_idx + 1'b1;
                    fill_count = fill_count - 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // An empty deque reports zeros; otherwise scan every live entry.
        r.entry_count = fill_count;
        if (fill_count != '0)
        begin
            r.front_value = ring_image[head_idx];
            idx = head_idx + IDX_W'(fill_count - 1'b1);
            r.back_value = ring_image[idx];
            hi = ring_image[head_idx];
            lo = ring_image[head_idx];
            for (int k = 0; k < int'(fill_count); k++)
            begin
                idx = head_idx + IDX_W'(k);
                if (ring_image[idx] > hi)
                    hi = ring_image[idx];
                if (ring_image[idx] < lo)
                    lo = ring_image[idx];
            end
            r.largest_value = hi;
            r.smallest_value = lo;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Values lean toward the signed extremes and small numbers so ties and sign flips occur.
    function automatic logic signed [dqmm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3:    return dqmm_pkg::VALUE_W'($urandom_range(0, 16)) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(logic [dqmm_pkg::OPCODE_W-1:0] op,
                           logic signed [dqmm_pkg::VALUE_W-1:0] value);
        dqmm_pkg::req_beat_t beat;
        beat.opcode = op;
        beat.push_value = value;
        pending_reqs.insert(pending_reqs.size(), beat);
    endtask

    task automatic check_field(string name, logic signed [dqmm_pkg::VALUE_W-1:0] exp_v,
                               logic signed [dqmm_pkg::VALUE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("report %0d: %s expected %0d, got %0d",
                         report_count, name, exp_v, act_v);
        end
    endtask

    // Request driver: presents queued beats with random gaps, holds a stalled beat steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_gap  = 0;
            send_calm = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_reports.insert(expected_reports.size(), apply_deque_op(req_data));
                accepted_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_reqs[0];
                    pending_reqs.delete(0);
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 24) == 0)
                            send_calm = $urandom_range(20, 80);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each accepted beat and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left = 0;
            hold_calm = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("report %0d: beat with nothing expected, got %p",
                                 report_count, rsp_data);
                end
                else
                begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    check_field("front_value", want.front_value, rsp_data.front_value);
                    check_field("back_value", want.back_value, rsp_data.back_value);
                    check_field("entry_count", dqmm_pkg::VALUE_W'(want.entry_count),
                                dqmm_pkg::VALUE_W'(rsp_data.entry_count));
                    check_field("largest_value", want.largest_value, rsp_data.largest_value);
                    check_field("smallest_value", want.smallest_value,
                                rsp_data.smallest_value);
                    check_field("status", dqmm_pkg::VALUE_W'(want.status),
                                dqmm_pkg::VALUE_W'(rsp_data.status));
                end
                report_count++;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (hold_calm > 0)
                begin
                    hold_calm--;
                end
                else
                begin
                    hold_left = pick_gap();
                    if ($urandom_range(0, 24) == 0)
                        hold_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int seg_left;
        int push_pct;
        int r;
        logic [dqmm_pkg::OPCODE_W-1:0] op;

        head_idx       = '0;
        fill_count     = '0;
        accepted_count = 0;
        report_count   = 0;
        mismatches     = 0;

        // Empty deque: query and both pops.
        add_req(dqmm_pkg::OP_QUERY, 32'sd0);
        add_req(dqmm_pkg::OP_POP_FRONT, pick_value());
        add_req(dqmm_pkg::OP_POP_BACK, pick_value());

        // Fill to capacity from both ends, extremes first.
        for (int i = 0; i < CAP; i++)
        begin
            op = i[0] ? dqmm_pkg::OP_PUSH_FRONT : dqmm_pkg::OP_PUSH_BACK;
            case (i)
                0:       add_req(op, 32'sh7fff_ffff);
                1:       add_req(op, 32'sh8000_0000);
                2:       add_req(op, 32'sd0);
                3:       add_req(op, -32'sd1);
                default: add_req(op, pick_value());
            endcase
        end

        // Pushes on a full deque are dropped.
        add_req(dqmm_pkg::OP_PUSH_FRONT, pick_value());
        add_req(dqmm_pkg::OP_PUSH_BACK, pick_value());

        // Undefined opcodes act as a query.
        for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
            add_req(dqmm_pkg::OPCODE_W'(u), pick_value());

        add_req(dqmm_pkg::OP_POP_FRONT, pick_value());
        add_req(dqmm_pkg::OP_POP_BACK, pick_value());

        // Random segments that lean toward filling or draining, so both ends are hit often.
        seg_left = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 5)
                op = dqmm_pkg::OPCODE_W'($urandom_range(dqmm_pkg::OP_QUERY, OP_UNUSED_HI));
            else if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? dqmm_pkg::OP_PUSH_FRONT : dqmm_pkg::OP_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? dqmm_pkg::OP_POP_FRONT : dqmm_pkg::OP_POP_BACK;
            add_req(op, pick_value());
        end
        total_items = pending_reqs.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items || expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        mismatches += expected_reports.size();
        if (mismatches == 0)
            $display("deque_with_min_max_tb: PASS");
        else
            $display("deque_with_min_max_tb: FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("deque_with_min_max_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dqmm_pkg.sv
hw/rtl/dqmm_minmax.sv
hw/rtl/deque_with_min_max.sv
verif/deque_with_min_max_tb.sv
